// File: rtl/core/hwc_pkg.sv
package hwc_pkg;

	// Fixed geometry
	localparam int LIGHT_CNT   = 64;
	localparam int LIGHT_W     = (LIGHT_CNT > 1) ? $clog2(LIGHT_CNT) : 1;
	localparam int PHASE_W     = 15;
	localparam int INC_W       = 8;
	localparam int HOLD_W      = 12;
	localparam int PERIOD_W    = 13;
	localparam int LEVEL_W     = 8;
	localparam int IDX_W       = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;

	localparam logic [PERIOD_W-1:0] PERIOD_BASE = 13'h100;
	localparam logic [INC_W-1:0]    INC_RESET   = 8'd8;
	localparam logic [HOLD_W-1:0]   HOLD_RESET  = 12'd1000;
	localparam logic [LEVEL_W-1:0]  FULL_LEVEL  = 8'hff;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = 2'd1;

	// Request operations
	localparam logic OPER_TICK = 1'b0;
	localparam logic OPER_LOAD = 1'b1;

	// Hue wheel segments
	localparam logic [2:0] SEG_RED_GREEN_UP  = 3'd0;
	localparam logic [2:0] SEG_RED_DOWN      = 3'd1;
	localparam logic [2:0] SEG_BLUE_UP       = 3'd2;
	localparam logic [2:0] SEG_GREEN_DOWN    = 3'd3;
	localparam logic [2:0] SEG_RED_UP        = 3'd4;
	localparam logic [2:0] SEG_BLUE_DOWN     = 3'd5;

	// Microprogram step addresses
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_READ  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_ADD   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_MOD4  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_MOD3  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_MOD2  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_MOD1  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_MOD0  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_WB    = 4'd8;
	localparam logic [STEP_W-1:0] STEP_SEG2  = 4'd9;
	localparam logic [STEP_W-1:0] STEP_SEG1  = 4'd10;
	localparam logic [STEP_W-1:0] STEP_SEG0  = 4'd11;
	localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd12;
	localparam logic [STEP_W-1:0] STEP_LOAD  = 4'd13;

	typedef enum logic [2:0] {
		OP_IDLE = 3'd0,
		OP_READ = 3'd1,
		OP_ADD  = 3'd2,
		OP_MOD  = 3'd3,
		OP_WB   = 3'd4,
		OP_SEG  = 3'd5,
		OP_EMIT = 3'd6,
		OP_LOAD = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		C_NEXT     = 2'd0,
		C_GOTO     = 2'd1,
		C_DISPATCH = 2'd2,
		C_EMIT     = 2'd3
	} cond_t;

	// One control word
	typedef struct packed {
		op_t               op;
		logic [2:0]        shamt;
		cond_t             cond;
		logic [STEP_W-1:0] target;
		logic              in_rdy;
	} ctl_t;

	// Status back to the sequencer
	typedef struct packed {
		logic acc;
		logic is_load;
		logic out_free;
		logic last;
	} sts_t;

	typedef struct packed {
		logic [INC_W-1:0]  inc;
		logic [HOLD_W-1:0] hold;
	} cfg_t;

	function automatic ctl_t mk(op_t op, logic [2:0] shamt, cond_t cond,
			logic [STEP_W-1:0] target, logic in_rdy);
		ctl_t c;
		c.op     = op;
		c.shamt  = shamt;
		c.cond   = cond;
		c.target = target;
		c.in_rdy = in_rdy;
		return c;
	endfunction

	// Microprogram ROM
	function automatic ctl_t ucode_rom(logic [STEP_W-1:0] pc);
		ctl_t c;
		c = mk(OP_IDLE, 3'd0, C_GOTO, STEP_IDLE, 1'b0);
		case (pc)
			STEP_IDLE: c = mk(OP_IDLE, 3'd0, C_DISPATCH, STEP_LOAD, 1'b1);
			STEP_READ: c = mk(OP_READ, 3'd0, C_NEXT, STEP_IDLE, 1'b0);
			STEP_ADD:  c = mk(OP_ADD,  3'd0, C_NEXT, STEP_IDLE, 1'b0);
			STEP_MOD4: c = mk(OP_MOD,  3'd4, C_NEXT, STEP_IDLE, 1'b0);
			STEP_MOD3: c = mk(OP_MOD,  3'd3, C_NEXT, STEP_IDLE, 1'b0);
			STEP_MOD2: c = mk(OP_MOD,  3'd2, C_NEXT, STEP_IDLE, 1'b0);
			STEP_MOD1: c = mk(OP_MOD,  3'd1, C_NEXT, STEP_IDLE, 1'b0);
			STEP_MOD0: c = mk(OP_MOD,  3'd0, C_NEXT, STEP_IDLE, 1'b0);
			STEP_WB:   c = mk(OP_WB,   3'd0, C_NEXT, STEP_IDLE, 1'b0);
			STEP_SEG2: c = mk(OP_SEG,  3'd2, C_NEXT, STEP_IDLE, 1'b0);
			STEP_SEG1: c = mk(OP_SEG,  3'd1, C_NEXT, STEP_IDLE, 1'b0);
			STEP_SEG0: c = mk(OP_SEG,  3'd0, C_NEXT, STEP_IDLE, 1'b0);
			STEP_EMIT: c = mk(OP_EMIT, 3'd0, C_EMIT, STEP_READ, 1'b0);
			STEP_LOAD: c = mk(OP_LOAD, 3'd0, C_GOTO, STEP_IDLE, 1'b0);
			default:   c = mk(OP_IDLE, 3'd0, C_GOTO, STEP_IDLE, 1'b0);
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/hwc_if.sv
// Request channel into the block
interface hwc_in_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [hwc_pkg::IDX_W-1:0]     light_index;
	logic [hwc_pkg::PHASE_W-1:0]   phase_value;

	modport source (output valid, operation, light_index, phase_value, input ready);
	modport sink   (input valid, operation, light_index, phase_value, output ready);
endinterface

// Colour results out of the block
interface hwc_out_if;
	logic                          valid;
	logic                          ready;
	logic [hwc_pkg::IDX_W-1:0]     light_number;
	logic [hwc_pkg::LEVEL_W-1:0]   red_level;
	logic [hwc_pkg::LEVEL_W-1:0]   green_level;
	logic [hwc_pkg::LEVEL_W-1:0]   blue_level;
	logic                          last_light;

	modport source (output valid, light_number, red_level, green_level, blue_level,
		last_light, input ready);
	modport sink   (input valid, light_number, red_level, green_level, blue_level,
		last_light, output ready);
endinterface

// Register write channel
interface hwc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hwc_pkg::CFG_IDX_W-1:0]  index;
	logic [hwc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/hwc_ram.sv
// Simple dual-port RAM, registered read
module hwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/hwc_seq.sv
// Microcode sequencer: step counter, control ROM, jump logic
module hwc_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  hwc_pkg::sts_t sts,
	output hwc_pkg::ctl_t ctl
);

	logic [hwc_pkg::STEP_W-1:0] pc_q;
	logic [hwc_pkg::STEP_W-1:0] pc_nxt;

	assign ctl = hwc_pkg::ucode_rom(pc_q);

	// Next step
	always_comb begin
		pc_nxt = pc_q;
		case (ctl.cond)
			hwc_pkg::C_NEXT: pc_nxt = pc_q + 1'b1;
			hwc_pkg::C_GOTO: pc_nxt = ctl.target;
			hwc_pkg::C_DISPATCH: begin
				if (sts.acc) begin
					pc_nxt = sts.is_load ? ctl.target : pc_q + 1'b1;
				end
			end
			hwc_pkg::C_EMIT: begin
				if (sts.out_free) begin
					pc_nxt = sts.last ? hwc_pkg::STEP_IDLE : ctl.target;
				end
			end
			default: pc_nxt = hwc_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= hwc_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

endmodule

// File: rtl/core/hwc_dp.sv
// Datapath: phase store, restoring modulo and segment steps, colour output
module hwc_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  hwc_pkg::ctl_t ctl,
	input  hwc_pkg::cfg_t cfg,
	output hwc_pkg::sts_t sts,
	hwc_in_if.sink        in_ch,
	hwc_out_if.source     out_ch
);

	localparam int LW = hwc_pkg::LIGHT_W;
	localparam int PW = hwc_pkg::PHASE_W;
	localparam int LIGHT_VEC = hwc_pkg::LIGHT_CNT;

	logic                          acc;
	logic [hwc_pkg::PERIOD_W-1:0]  period;
	logic [PW-1:0]                 full;
	logic [PW+3:0]                 full_sh;
	logic [PW+4:0]                 mod_diff;
	logic [PW-1:0]                 per_sh;
	logic [PW:0]                   seg_diff;
	logic [PW-1:0]                 rd_ph;
	logic [PW-1:0]                 ram_rdata;
	logic [PW-1:0]                 ld_clamped;
	logic                          ld_in_range;
	logic                          ram_we;
	logic [LW-1:0]                 ram_waddr;
	logic [PW-1:0]                 ram_wdata;
	logic                          out_free;
	logic                          emit_go;
	logic [hwc_pkg::LEVEL_W-1:0]   off;
	logic [hwc_pkg::LEVEL_W-1:0]   r_c, g_c, b_c;

	logic [LW-1:0]                 light_q;
	logic [LIGHT_VEC-1:0]          vld_q;
	logic [PW:0]                   p_q;
	logic [PW-1:0]                 rem_q;
	logic [2:0]                    seg_q;
	logic [hwc_pkg::IDX_W-1:0]     ld_idx_q;
	logic [PW-1:0]                 ld_val_q;
	logic                          out_vld_q;
	logic [hwc_pkg::IDX_W-1:0]     out_num_q;
	logic [hwc_pkg::LEVEL_W-1:0]   out_r_q, out_g_q, out_b_q;
	logic                          out_last_q;

	// Handshake and status
	assign in_ch.ready  = ctl.in_rdy;
	assign acc          = in_ch.valid & ctl.in_rdy;
	assign out_free     = !out_vld_q || out_ch.ready;
	assign emit_go      = (ctl.op == hwc_pkg::OP_EMIT) && out_free;
	assign sts.acc      = acc;
	assign sts.is_load  = (in_ch.operation == hwc_pkg::OPER_LOAD);
	assign sts.out_free = out_free;
	assign sts.last     = (light_q == LW'(hwc_pkg::LIGHT_CNT - 1));

	// Period and six-period span from the hold time
	assign period = hwc_pkg::PERIOD_BASE + hwc_pkg::PERIOD_W'(cfg.hold);
	assign full   = {period, 2'b00} + PW'({period, 1'b0});

	// Restoring steps on shifted divisors
	assign full_sh  = {4'b0, full} << ctl.shamt;
	assign mod_diff = {4'b0, p_q} - {1'b0, full_sh};
	assign per_sh   = {2'b0, period} << ctl.shamt;
	assign seg_diff = {1'b0, rem_q} - {1'b0, per_sh};

	// Unwritten lights read as zero
	assign rd_ph = vld_q[light_q] ? ram_rdata : '0;

	// Load clamp and range check
	assign ld_clamped  = (ld_val_q >= full) ? (full - PW'(1)) : ld_val_q;
	assign ld_in_range = ({1'b0, ld_idx_q} < 7'(hwc_pkg::LIGHT_CNT));

	// Phase store write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = light_q;
		ram_wdata = p_q[PW-1:0];
		if (ctl.op == hwc_pkg::OP_WB) begin
			ram_we = 1'b1;
		end else if (ctl.op == hwc_pkg::OP_LOAD) begin
			ram_we    = ld_in_range;
			ram_waddr = ld_idx_q[LW-1:0];
			ram_wdata = ld_clamped;
		end
	end

	hwc_ram #(
		.WIDTH (PW),
		.DEPTH (hwc_pkg::LIGHT_CNT)
	) u_phase_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (light_q),
		.rdata (ram_rdata)
	);

	// Hue wheel colour
	assign off = (rem_q > PW'(hwc_pkg::FULL_LEVEL)) ? hwc_pkg::FULL_LEVEL
		: rem_q[hwc_pkg::LEVEL_W-1:0];

	always_comb begin
		r_c = hwc_pkg::FULL_LEVEL;
		g_c = '0;
		b_c = hwc_pkg::FULL_LEVEL - off;
		case (seg_q)
			hwc_pkg::SEG_RED_GREEN_UP: begin
				r_c = hwc_pkg::FULL_LEVEL; g_c = off; b_c = '0;
			end
			hwc_pkg::SEG_RED_DOWN: begin
				r_c = hwc_pkg::FULL_LEVEL - off; g_c = hwc_pkg::FULL_LEVEL; b_c = '0;
			end
			hwc_pkg::SEG_BLUE_UP: begin
				r_c = '0; g_c = hwc_pkg::FULL_LEVEL; b_c = off;
			end
			hwc_pkg::SEG_GREEN_DOWN: begin
				r_c = '0; g_c = hwc_pkg::FULL_LEVEL - off; b_c = hwc_pkg::FULL_LEVEL;
			end
			hwc_pkg::SEG_RED_UP: begin
				r_c = off; g_c = '0; b_c = hwc_pkg::FULL_LEVEL;
			end
			default: begin
				r_c = hwc_pkg::FULL_LEVEL; g_c = '0; b_c = hwc_pkg::FULL_LEVEL - off;
			end
		endcase
	end

	// Control registers: light counter, valid bits, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q   <= '0;
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc && in_ch.operation == hwc_pkg::OPER_TICK) begin
				light_q <= '0;
			end else if (emit_go) begin
				light_q <= light_q + 1'b1;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (emit_go) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (acc) begin
			ld_idx_q <= in_ch.light_index;
			ld_val_q <= in_ch.phase_value;
		end
		case (ctl.op)
			hwc_pkg::OP_ADD: p_q <= {1'b0, rd_ph} + (PW + 1)'(cfg.inc);
			hwc_pkg::OP_MOD: begin
				if (!mod_diff[PW+4]) begin
					p_q <= mod_diff[PW:0];
				end
			end
			hwc_pkg::OP_WB: begin
				rem_q <= p_q[PW-1:0];
				seg_q <= '0;
			end
			hwc_pkg::OP_SEG: begin
				if (!seg_diff[PW]) begin
					rem_q               <= seg_diff[PW-1:0];
					seg_q[ctl.shamt[1:0]] <= 1'b1;
				end
			end
			default: ;
		endcase
		if (emit_go) begin
			out_num_q  <= hwc_pkg::IDX_W'(light_q);
			out_r_q    <= r_c;
			out_g_q    <= g_c;
			out_b_q    <= b_c;
			out_last_q <= sts.last;
		end
	end

	assign out_ch.valid        = out_vld_q;
	assign out_ch.light_number = out_num_q;
	assign out_ch.red_level    = out_r_q;
	assign out_ch.green_level  = out_g_q;
	assign out_ch.blue_level   = out_b_q;
	assign out_ch.last_light   = out_last_q;

	// Phase written back is always inside six periods
	a_wb_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == hwc_pkg::OP_WB |-> p_q < {1'b0, full})
		else $error("phase not reduced before write-back");

	// Segment never reaches six
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == hwc_pkg::OP_EMIT |-> seg_q <= hwc_pkg::SEG_BLUE_DOWN)
		else $error("segment out of range");

	// A result only appears after an emit step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(ctl.op == hwc_pkg::OP_EMIT))
		else $error("result without emit step");

endmodule

// File: rtl/core/led_hue_wheel_cycler_core.sv
// Load request: accepted in the idle step, phase stored in the step that follows.
// Tick request: accepted in the idle step, then 12 microcode steps per light (read, add, five
// modulo steps, write-back, three segment steps, emit) for each of the 64 lights.
// The first result is registered in light 0's emit step; a stalled output holds the emit step.
// Reset (arst_n low) returns the sequencer to idle, all phases read as zero,
// phase_increment to 8 and hold_time to 1000.
module led_hue_wheel_cycler_core (
	input  logic      clk,
	input  logic      arst_n,
	hwc_in_if.sink    in_ch,
	hwc_out_if.source out_ch,
	hwc_cfg_if.sink   cfg
);

	hwc_pkg::ctl_t ctl;
	hwc_pkg::sts_t sts;
	hwc_pkg::cfg_t cfg_q;

	// Register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inc  <= hwc_pkg::INC_RESET;
			cfg_q.hold <= hwc_pkg::HOLD_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == hwc_pkg::REG_PHASE_INC) begin
				cfg_q.inc <= cfg.data[hwc_pkg::INC_W-1:0];
			end else if (cfg.index == hwc_pkg::REG_HOLD_TIME) begin
				cfg_q.hold <= cfg.data[hwc_pkg::HOLD_W-1:0];
			end
		end
	end

	hwc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	hwc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cfg    (cfg_q),
		.sts    (sts),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

// File: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [hwc_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [hwc_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
	localparam int unsigned SEG_COUNT      = 6;
	localparam int          SETTLE_CYCLES  = 20;
	localparam int          TAIL_CYCLES    = 60;
	localparam int          STALL_CYCLES   = 600;
	localparam int          WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic [hwc_pkg::IDX_W-1:0]   light;
		logic [hwc_pkg::LEVEL_W-1:0] red;
		logic [hwc_pkg::LEVEL_W-1:0] green;
		logic [hwc_pkg::LEVEL_W-1:0] blue;
		logic                        last_flag;
	} light_colour_t;

	logic clk = 1'b0;
	logic arst_n;

	hwc_in_if  in_ch();
	hwc_out_if out_ch();
	hwc_cfg_if cfg_ch();

	led_hue_wheel_cycler_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// Own copy of the light phases and the two registers
	logic [hwc_pkg::PHASE_W-1:0] phase_mem [hwc_pkg::LIGHT_CNT];
	logic [hwc_pkg::INC_W-1:0]   step_amt = hwc_pkg::INC_RESET;
	logic [hwc_pkg::HOLD_W-1:0]  dwell    = hwc_pkg::HOLD_RESET;

	light_colour_t colour_q[$];
	int            mismatches  = 0;
	int            quiet_cycles = 0;
	bit            tx_idle_en  = 1'b0;
	bit            rx_idle_en  = 1'b0;
	int            rx_hold_len = 0;

	initial begin
		for (int i = 0; i < hwc_pkg::LIGHT_CNT; i++) phase_mem[i] = '0;
	end

	function automatic int unsigned wheel_period();
		return hwc_pkg::PERIOD_BASE + dwell;
	endfunction

	// Load: clamp to one below six periods
	function automatic void store_phase(logic [hwc_pkg::IDX_W-1:0] idx,
			logic [hwc_pkg::PHASE_W-1:0] val);
		int unsigned span;
		span = SEG_COUNT * wheel_period();
		if (val >= span) phase_mem[idx] = hwc_pkg::PHASE_W'(span - 1);
		else phase_mem[idx] = val;
	endfunction

	// Tick: step every light round the wheel and queue its colour
	function automatic void advance_lights();
		int unsigned   per, span, p, seg, ramp;
		logic [hwc_pkg::LEVEL_W-1:0] lvl;
		light_colour_t c;
		per  = wheel_period();
		span = SEG_COUNT * per;
		for (int i = 0; i < hwc_pkg::LIGHT_CNT; i++) begin
			p = phase_mem[i] + step_amt;
			// a phase left over from a longer hold may lie far beyond the wheel
			if (p >= span) p = p % span;
			phase_mem[i] = hwc_pkg::PHASE_W'(p);
			seg  = p / per;
			ramp = p % per;
			if (ramp > hwc_pkg::FULL_LEVEL) ramp = hwc_pkg::FULL_LEVEL;
			lvl = hwc_pkg::LEVEL_W'(ramp);
			c.light     = hwc_pkg::IDX_W'(i);
			c.last_flag = (i == hwc_pkg::LIGHT_CNT - 1);
			case (seg)
				hwc_pkg::SEG_RED_GREEN_UP: begin
					c.red = hwc_pkg::FULL_LEVEL; c.green = lvl; c.blue = '0;
				end
				hwc_pkg::SEG_RED_DOWN: begin
					c.red = hwc_pkg::FULL_LEVEL - lvl; c.green = hwc_pkg::FULL_LEVEL;
					c.blue = '0;
				end
				hwc_pkg::SEG_BLUE_UP: begin
					c.red = '0; c.green = hwc_pkg::FULL_LEVEL; c.blue = lvl;
				end
				hwc_pkg::SEG_GREEN_DOWN: begin
					c.red = '0; c.green = hwc_pkg::FULL_LEVEL - lvl;
					c.blue = hwc_pkg::FULL_LEVEL;
				end
				hwc_pkg::SEG_RED_UP: begin
					c.red = lvl; c.green = '0; c.blue = hwc_pkg::FULL_LEVEL;
				end
				default: begin
					c.red = hwc_pkg::FULL_LEVEL; c.green = '0;
					c.blue = hwc_pkg::FULL_LEVEL - lvl;
				end
			endcase
			colour_q.push_back(c);
		end
	endfunction

	// Phases biased towards the wheel end and the clamp region
	function automatic logic [hwc_pkg::PHASE_W-1:0] pick_phase();
		int unsigned span;
		span = SEG_COUNT * wheel_period();
		case ($urandom_range(0, 3))
			0: return hwc_pkg::PHASE_W'(span - 1 - $urandom_range(0, 40));
			1: return hwc_pkg::PHASE_W'($urandom_range(span, 32767));
			default: return hwc_pkg::PHASE_W'($urandom_range(0, 32767));
		endcase
	endfunction

	// One request on the input channel; valid is left high for a back-to-back follower
	task automatic send_request(input logic op, input logic [hwc_pkg::IDX_W-1:0] idx,
			input logic [hwc_pkg::PHASE_W-1:0] val);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.operation   <= op;
		in_ch.light_index <= idx;
		in_ch.phase_value <= val;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		if (op == hwc_pkg::OPER_LOAD) store_phase(idx, val);
		else advance_lights();
	endtask

	task automatic send_random_request();
		if ($urandom_range(0, 3) == 0)
			send_request(hwc_pkg::OPER_TICK, hwc_pkg::IDX_W'($urandom),
				hwc_pkg::PHASE_W'($urandom));
		else
			send_request(hwc_pkg::OPER_LOAD, hwc_pkg::IDX_W'($urandom_range(0, 63)),
				pick_phase());
	endtask

	// Stop offering and wait until every queued colour has come out
	task automatic wait_for_colours();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (colour_q.size() != 0);
	endtask

	// Registers only change with the block idle
	task automatic write_register(input logic [hwc_pkg::CFG_IDX_W-1:0] idx,
			input logic [hwc_pkg::CFG_DATA_W-1:0] data);
		wait_for_colours();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		case (idx)
			hwc_pkg::REG_PHASE_INC: step_amt = data[hwc_pkg::INC_W-1:0];
			hwc_pkg::REG_HOLD_TIME: dwell    = data[hwc_pkg::HOLD_W-1:0];
			default: ;
		endcase
	endtask

	// Tick straight out of reset: every light one step into the first segment
	task automatic test_reset_defaults();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_request(hwc_pkg::OPER_TICK, '0, '0);
	endtask

	// Loads at the field extremes, one per segment, hold region, clamp and wrap
	task automatic test_load_edges();
		int unsigned per, span;
		per  = wheel_period();
		span = SEG_COUNT * per;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_request(hwc_pkg::OPER_LOAD, 6'd0, 15'd0);
		send_request(hwc_pkg::OPER_LOAD, 6'd63, 15'h7fff);
		for (int k = 0; k < SEG_COUNT; k++)
			send_request(hwc_pkg::OPER_LOAD, hwc_pkg::IDX_W'(2 + k),
				hwc_pkg::PHASE_W'(k * per + 100));
		send_request(hwc_pkg::OPER_LOAD, 6'd8, hwc_pkg::PHASE_W'(per + 600));
		send_request(hwc_pkg::OPER_LOAD, 6'd9, hwc_pkg::PHASE_W'(span - 1 - step_amt));
		send_request(hwc_pkg::OPER_LOAD, 6'd10, hwc_pkg::PHASE_W'(span - step_amt));
		send_request(hwc_pkg::OPER_LOAD, 6'd11, hwc_pkg::PHASE_W'(span - 3));
		send_request(hwc_pkg::OPER_LOAD, 6'd12, hwc_pkg::PHASE_W'(span));
		send_request(hwc_pkg::OPER_LOAD, 6'd13, hwc_pkg::PHASE_W'(span - 1));
		send_request(hwc_pkg::OPER_TICK, 6'd63, 15'h7fff);
	endtask

	// Register extremes, masked data bits, unknown indexes and a shortened hold
	task automatic test_register_extremes();
		write_register(hwc_pkg::REG_PHASE_INC, 12'hf00);
		write_register(hwc_pkg::REG_HOLD_TIME, '0);
		send_request(hwc_pkg::OPER_TICK, '0, '0);
		write_register(hwc_pkg::REG_PHASE_INC, 12'h0ff);
		write_register(hwc_pkg::REG_HOLD_TIME, 12'hfff);
		send_request(hwc_pkg::OPER_LOAD, 6'd20, 15'h7fff);
		send_request(hwc_pkg::OPER_LOAD, 6'd21, 15'd20000);
		send_request(hwc_pkg::OPER_TICK, '0, '0);
		// stored phases now lie far past the shorter wheel
		write_register(hwc_pkg::REG_HOLD_TIME, '0);
		send_request(hwc_pkg::OPER_TICK, '0, '0);
		write_register(REG_UNUSED_2, 12'hfff);
		write_register(REG_UNUSED_3, 12'hfff);
		send_request(hwc_pkg::OPER_TICK, '0, '0);
	endtask

	// Long output stall while ticks keep coming, so the input backs up
	task automatic test_backpressure();
		write_register(hwc_pkg::REG_PHASE_INC, 12'd37);
		write_register(hwc_pkg::REG_HOLD_TIME, 12'd300);
		tx_idle_en  = 1'b0;
		rx_idle_en  = 1'b0;
		rx_hold_len = STALL_CYCLES;
		send_request(hwc_pkg::OPER_TICK, '0, '0);
		send_request(hwc_pkg::OPER_LOAD, 6'd5, pick_phase());
		send_request(hwc_pkg::OPER_TICK, '0, '0);
		send_request(hwc_pkg::OPER_TICK, '0, '0);
	endtask

	// Sender goes quiet until the block has drained, then resumes
	task automatic test_sender_pause();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (5) send_random_request();
		send_request(hwc_pkg::OPER_TICK, '0, '0);
		wait_for_colours();
		repeat (5) send_random_request();
	endtask

	// Random mix under a series of register settings
	task automatic test_random_mix();
		logic [hwc_pkg::INC_W-1:0]  inc;
		logic [hwc_pkg::HOLD_W-1:0] hold;
		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(0, 2))
				0: inc = '0;
				1: inc = '1;
				default: inc = hwc_pkg::INC_W'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 2))
				0: hold = '0;
				1: hold = '1;
				default: hold = hwc_pkg::HOLD_W'($urandom_range(0, 4095));
			endcase
			if (ph == 0) begin
				inc  = '1;
				hold = '0;
			end
			write_register(hwc_pkg::REG_PHASE_INC, {4'($urandom_range(0, 15)), inc});
			write_register(hwc_pkg::REG_HOLD_TIME, hold);
			if ($urandom_range(0, 1) == 1)
				write_register(($urandom_range(0, 1) == 1) ? REG_UNUSED_2 : REG_UNUSED_3,
					hwc_pkg::CFG_DATA_W'($urandom));
			tx_idle_en = ph[0];
			rx_idle_en = ph[1];
			repeat (65) send_random_request();
		end
	endtask

	// Result side: random gaps between results, one long hold when asked
	initial begin : colour_sink
		int gap;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_len > 0) begin
				gap = rx_hold_len;
				rx_hold_len = 0;
			end else begin
				gap = rx_idle_en ? $urandom_range(0, 9) : 0;
			end
			if (gap != 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
		end
	end

	// Compare each colour with the oldest expectation
	always @(posedge clk) begin : colour_check
		light_colour_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (colour_q.size() == 0) begin
				$error("unexpected colour for light %0d", out_ch.light_number);
				mismatches++;
			end else begin
				want = colour_q.pop_front();
				if (out_ch.light_number !== want.light) begin
					$error("light_number: expected %0d, got %0d", want.light,
						out_ch.light_number);
					mismatches++;
				end
				if (out_ch.red_level !== want.red) begin
					$error("red_level: expected %0d, got %0d", want.red, out_ch.red_level);
					mismatches++;
				end
				if (out_ch.green_level !== want.green) begin
					$error("green_level: expected %0d, got %0d", want.green,
						out_ch.green_level);
					mismatches++;
				end
				if (out_ch.blue_level !== want.blue) begin
					$error("blue_level: expected %0d, got %0d", want.blue, out_ch.blue_level);
					mismatches++;
				end
				if (out_ch.last_light !== want.last_flag) begin
					$error("last_light: expected %0d, got %0d", want.last_flag,
						out_ch.last_light);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles without any handshake on the request, result or register channel
	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : test_sequence
		arst_n            <= 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.operation   <= hwc_pkg::OPER_TICK;
		in_ch.light_index <= '0;
		in_ch.phase_value <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= hwc_pkg::REG_PHASE_INC;
		cfg_ch.data       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_load_edges();
		test_register_extremes();
		test_backpressure();
		test_sender_pause();
		test_random_mix();

		wait_for_colours();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && colour_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/hwc_pkg.sv
rtl/core/hwc_if.sv
rtl/core/hwc_ram.sv
rtl/core/hwc_seq.sv
rtl/core/hwc_dp.sv
rtl/core/led_hue_wheel_cycler_core.sv
tb/tb_top.sv
